// File: rtl/core/bbe_pkg.sv
// ----------------------------------------------------------------------------
// Bollinger band engine package
// Shared widths, register map, reset values and handshake types between the
// sequencer and the iterative root/divide unit.
// ----------------------------------------------------------------------------
package bbe_pkg;

   // Default build parameters
   localparam int DEF_MAX_WINDOW = 64;
   localparam int DEF_PRICE_BITS = 24;

   // Configuration register widths and reset values
   localparam int WLEN_W      = 7;
   localparam int MULT_W      = 12;
   localparam int WLEN_RESET  = 20;
   localparam int MULT_RESET  = 512;

   // Result field widths
   localparam int LOWER_W  = 29;
   localparam int MIDDLE_W = 24;
   localparam int UPPER_W  = 29;

   // Fraction bits of the deviation multiplier
   localparam int FRAC_BITS = 8;

   // CSR port: two 32-bit registers at byte offsets 0 and 4
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_IDX_W  = 1;
   localparam logic [CSR_IDX_W-1:0] REG_WLEN = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_MULT = 1'b1;

   // Command into the shared root/divide unit
   typedef struct packed {
      logic start;
      logic is_sqrt;
   } bbe_iter_ctl_type;

   // Status back from the shared root/divide unit
   typedef struct packed {
      logic busy;
      logic done;
   } bbe_iter_stat_type;

   function automatic int imax(input int a, input int b);
      return (a > b) ? a : b;
   endfunction

endpackage

// File: rtl/core/bbe_ring.sv
// ----------------------------------------------------------------------------
// Price ring
// Single-port-write, single-port-read memory holding the window prices.
// Read data is registered.
// ----------------------------------------------------------------------------
module bbe_ring #(
   parameter int DEPTH = bbe_pkg::DEF_MAX_WINDOW,
   parameter int WIDTH = bbe_pkg::DEF_PRICE_BITS,
   parameter int AW    = $clog2(bbe_pkg::DEF_MAX_WINDOW)
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);
   import bbe_pkg::*;

   logic [WIDTH-1:0] ram_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bbe_mul.sv
// ----------------------------------------------------------------------------
// Shared multiplier
// One registered W x W unsigned multiplier; the sequencer steers its
// operands per state.
// ----------------------------------------------------------------------------
module bbe_mul #(
   parameter int W = 30
) (
   input  logic           clock,
   input  logic [W-1:0]   op_a,
   input  logic [W-1:0]   op_b,
   output logic [2*W-1:0] product
);
   import bbe_pkg::*;

   localparam int PW = 2 * W;

   logic [PW-1:0] prod_ff;
   logic [PW-1:0] prod_in;

   assign prod_in = PW'(op_a) * PW'(op_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

   assign product = prod_ff;

endmodule

// File: rtl/core/bbe_iter.sv
// ----------------------------------------------------------------------------
// Iterative root / divide unit
// Restoring shift-subtract engine: one quotient bit or one root bit per
// cycle, QOW bits per operation.
// ----------------------------------------------------------------------------
module bbe_iter #(
   parameter int QOW  = 31,
   parameter int DIVW = bbe_pkg::WLEN_W
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bbe_pkg::bbe_iter_ctl_type   ctl,
   input  logic [2*QOW-1:0]            operand,
   input  logic [DIVW-1:0]             divisor,
   output bbe_pkg::bbe_iter_stat_type  stat,
   output logic [QOW-1:0]              result
);
   import bbe_pkg::*;

   localparam int XW   = 2 * QOW;
   localparam int RW   = QOW + 1;
   localparam int TW   = QOW + 3;
   localparam int CNTW = $clog2(QOW + 1);

   logic [XW-1:0]   x_ff, x_in;
   logic [RW-1:0]   rem_ff, rem_in;
   logic [QOW-1:0]  q_ff, q_in;
   logic [CNTW-1:0] cnt_ff, cnt_in;
   logic            run_ff, run_in;
   logic            sqrt_ff, sqrt_in;
   logic            done_ff, done_in;

   logic [TW-1:0]   rem_sh;
   logic [TW-1:0]   trial;
   logic [TW-1:0]   diff;
   logic            ge;

   // Bring down the next digit(s) and try the subtract
   always_comb begin
      if (sqrt_ff) begin
         rem_sh = {rem_ff, x_ff[XW-1 -: 2]};
         trial  = TW'({q_ff, 2'b01});
      end else begin
         rem_sh = TW'({rem_ff, x_ff[XW-1]});
         trial  = TW'(divisor);
      end
      ge   = (rem_sh >= trial);
      diff = rem_sh - trial;
   end

   always_comb begin
      x_in    = x_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      run_in  = run_ff;
      sqrt_in = sqrt_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         x_in    = operand;
         rem_in  = '0;
         q_in    = '0;
         cnt_in  = CNTW'(QOW);
         run_in  = 1'b1;
         sqrt_in = ctl.is_sqrt;
      end else if (run_ff) begin
         x_in   = sqrt_ff ? (x_ff << 2) : (x_ff << 1);
         rem_in = ge ? RW'(diff) : RW'(rem_sh);
         q_in   = {q_ff[QOW-2:0], ge};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNTW'(1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
         sqrt_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
         sqrt_ff <= sqrt_in;
      end
      x_ff   <= x_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
   end

   assign stat.busy = run_ff;
   assign stat.done = done_ff;
   assign result    = q_ff;

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !run_ff)
      else $error("iter: start while busy");

   a_done_follows_run: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(run_ff))
      else $error("iter: done without a running operation");

   a_count_live: assert property (@(posedge clock) disable iff (reset)
      run_ff |-> (cnt_ff != '0))
      else $error("iter: running with exhausted step count");

endmodule

// File: rtl/core/bollinger_band_engine_unit.sv
// Each request with a full window runs a square root and two divisions
//   through the root/divide unit, one bit per cycle; QOW is 31 at the default
//   parameters. A new request is stalled until the sequencer is back in idle,
//   which waits for the response register to be free.
// Reset: synchronous, active high; clears the window, both sums and the
//   sequencer and loads window_length 20, deviation_multiplier 512.
// ----------------------------------------------------------------------------
// Bollinger band engine
// Keeps a sliding window of prices with running sum and sum of squares and
// emits the lower, middle and upper band for each price once the window is
// full. One multiplier and one root/divide unit are shared under a sequencer.
// ----------------------------------------------------------------------------
module bollinger_band_engine_unit #(
   parameter int MAX_WINDOW = bbe_pkg::DEF_MAX_WINDOW,
   parameter int PRICE_BITS = bbe_pkg::DEF_PRICE_BITS
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // Request channel
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  logic [PRICE_BITS-1:0]                  req_price,
   // Response channel
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic signed [bbe_pkg::LOWER_W-1:0]     rsp_lower_band,
   output logic [bbe_pkg::MIDDLE_W-1:0]           rsp_middle_band,
   output logic [bbe_pkg::UPPER_W-1:0]            rsp_upper_band,
   // CSR port
   input  logic                                   csr_psel,
   input  logic                                   csr_penable,
   input  logic                                   csr_pwrite,
   input  logic [bbe_pkg::CSR_ADDR_W-1:0]         csr_paddr,
   input  logic [bbe_pkg::CSR_DATA_W-1:0]         csr_pwdata,
   output logic [bbe_pkg::CSR_DATA_W-1:0]         csr_prdata,
   output logic                                   csr_pready
);
   import bbe_pkg::*;

   // Derived widths
   localparam int AW    = $clog2(MAX_WINDOW);        // ring slot index
   localparam int SW    = PRICE_BITS + AW;           // running sum
   localparam int QW    = 2 * PRICE_BITS + AW;       // running sum of squares
   localparam int MUL_W = imax(SW, MULT_W);          // shared multiplier operand
   localparam int VW    = QW + WLEN_W;               // n * sum of squares
   localparam int HW    = (VW + 1) / 2;              // root of the spread
   localparam int QOW   = imax(HW, SW);              // root/quotient width
   localparam int XW    = 2 * QOW;                   // root/divide operand
   localparam int PRW   = 2 * MUL_W;                 // product width
   localparam int CMPW  = imax(VW, PRW);             // spread compare width
   localparam int BIGW  = imax(PRW, LOWER_W + 1);    // band arithmetic width

   // Sequencer states
   localparam logic [3:0] ST_IDLE = 4'd0;   // wait for a request
   localparam logic [3:0] ST_SQP  = 4'd1;   // square new price
   localparam logic [3:0] ST_SQO  = 4'd2;   // hold new price operands, write ring
   localparam logic [3:0] ST_ADD  = 4'd3;   // add new price, square evicted price
   localparam logic [3:0] ST_SUB  = 4'd4;   // drop evicted price, advance slot
   localparam logic [3:0] ST_MQL  = 4'd5;   // n * low half of square sum
   localparam logic [3:0] ST_MQH  = 4'd6;   // n * high half of square sum
   localparam logic [3:0] ST_MSS  = 4'd7;   // sum * sum
   localparam logic [3:0] ST_VAR  = 4'd8;   // spread, launch square root
   localparam logic [3:0] ST_ROOT = 4'd9;   // wait root, launch mean divide
   localparam logic [3:0] ST_MEAN = 4'd10;  // wait mean, launch deviation divide
   localparam logic [3:0] ST_DEV  = 4'd11;  // wait deviation, multiply by k
   localparam logic [3:0] ST_OFS  = 4'd12;  // form bands, hand to output

   // Registers
   logic [3:0]               state_ff, state_in;
   logic [WLEN_W-1:0]        wlen_ff, wlen_in;
   logic [MULT_W-1:0]        mult_ff, mult_in;
   logic [AW-1:0]            slot_ff, slot_in;
   logic [WLEN_W-1:0]        fill_ff, fill_in;
   logic [SW-1:0]            sum_ff, sum_in;
   logic [QW-1:0]            sq_ff, sq_in;
   logic [PRICE_BITS-1:0]    price_ff, price_in;
   logic [VW-1:0]            spread_ff, spread_in;
   logic [QOW-1:0]           root_ff, root_in;
   logic [SW-1:0]            mean_ff, mean_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [LOWER_W-1:0]       lower_ff, lower_in;
   logic [MIDDLE_W-1:0]      middle_ff, middle_in;
   logic [UPPER_W-1:0]       upper_ff, upper_in;

   // Datapath wires
   logic [WLEN_W-1:0]        n_len;
   logic                     req_fire;
   logic                     csr_wr;
   logic [CSR_IDX_W-1:0]     csr_idx;
   logic [PRICE_BITS-1:0]    old_price;
   logic [MUL_W-1:0]         mul_a;
   logic [MUL_W-1:0]         mul_b;
   logic [PRW-1:0]           prod;
   bbe_iter_ctl_type         iter_ctl;
   bbe_iter_stat_type        iter_stat;
   logic [XW-1:0]            iter_opnd;
   logic [QOW-1:0]           iter_res;
   logic [CMPW-1:0]          spread_c;
   logic [CMPW-1:0]          sqsum_c;
   logic [CMPW-1:0]          var_c;
   logic [BIGW-1:0]          ofs_big;
   logic [BIGW-1:0]          mean_big;
   logic [BIGW-1:0]          lo_big;
   logic [BIGW-1:0]          up_big;
   logic                     win_full;
   logic                     rsp_free;

   // Clamp the window length: zero acts as one, oversize acts as MAX_WINDOW
   always_comb begin
      if (wlen_ff == '0) begin
         n_len = WLEN_W'(1);
      end else if (32'(wlen_ff) > MAX_WINDOW) begin
         n_len = WLEN_W'(MAX_WINDOW);
      end else begin
         n_len = wlen_ff;
      end
   end

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign win_full   = (fill_ff >= n_len);
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      case (csr_idx)
         REG_WLEN: csr_prdata = CSR_DATA_W'(wlen_ff);
         REG_MULT: csr_prdata = CSR_DATA_W'(mult_ff);
         default:  csr_prdata = '0;
      endcase
   end

   // Price ring: read the evicted price at accept, overwrite it in the SQO state
   bbe_ring #(
      .DEPTH (MAX_WINDOW),
      .WIDTH (PRICE_BITS),
      .AW    (AW)
   ) u_ring (
      .clock   (clock),
      .wr_en   (state_ff == ST_SQO),
      .wr_addr (slot_ff),
      .wr_data (price_ff),
      .rd_en   (req_fire),
      .rd_addr (slot_ff),
      .rd_data (old_price)
   );

   // Steer the shared multiplier; its product is registered
   always_comb begin
      case (state_ff)
         ST_SQP, ST_SQO: begin
            mul_a = MUL_W'(price_ff);
            mul_b = MUL_W'(price_ff);
         end
         ST_MQL: begin
            mul_a = MUL_W'(n_len);
            mul_b = sq_ff[MUL_W-1:0];
         end
         ST_MQH: begin
            mul_a = MUL_W'(n_len);
            mul_b = MUL_W'(sq_ff[QW-1:MUL_W]);
         end
         ST_MSS: begin
            mul_a = MUL_W'(sum_ff);
            mul_b = MUL_W'(sum_ff);
         end
         ST_DEV, ST_OFS: begin
            // Deviation stays in the iter result register while bands form
            mul_a = MUL_W'(mult_ff);
            mul_b = MUL_W'(iter_res);
         end
         default: begin
            mul_a = MUL_W'(old_price);
            mul_b = MUL_W'(old_price);
         end
      endcase
   end

   bbe_mul #(
      .W (MUL_W)
   ) u_mul (
      .clock   (clock),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .product (prod)
   );

   // Spread n*Q - S*S, floored at zero
   assign spread_c = CMPW'(spread_ff);
   assign sqsum_c  = CMPW'(prod);
   assign var_c    = (spread_c >= sqsum_c) ? (spread_c - sqsum_c) : '0;

   // Launch the root/divide unit: root in VAR, mean when the root lands,
   // deviation when the mean lands
   always_comb begin
      iter_ctl.start   = 1'b0;
      iter_ctl.is_sqrt = 1'b0;
      iter_opnd        = XW'(var_c);
      case (state_ff)
         ST_VAR: begin
            iter_ctl.start   = 1'b1;
            iter_ctl.is_sqrt = 1'b1;
         end
         ST_ROOT: begin
            iter_ctl.start = iter_stat.done;
            iter_opnd      = {QOW'(sum_ff), {QOW{1'b0}}};
         end
         ST_MEAN: begin
            iter_ctl.start = iter_stat.done;
            iter_opnd      = {root_ff, {QOW{1'b0}}};
         end
         default: begin
            iter_ctl.start = 1'b0;
         end
      endcase
   end

   bbe_iter #(
      .QOW  (QOW),
      .DIVW (WLEN_W)
   ) u_iter (
      .clock   (clock),
      .reset   (reset),
      .ctl     (iter_ctl),
      .operand (iter_opnd),
      .divisor (n_len),
      .stat    (iter_stat),
      .result  (iter_res)
   );

   // Bands: offset = k * dev >> 8, then mean minus/plus offset mod 2^29
   assign ofs_big  = BIGW'(prod >> FRAC_BITS);
   assign mean_big = BIGW'(mean_ff);
   assign lo_big   = mean_big - ofs_big;
   assign up_big   = mean_big + ofs_big;

   always_comb begin
      state_in     = state_ff;
      wlen_in      = wlen_ff;
      mult_in      = mult_ff;
      slot_in      = slot_ff;
      fill_in      = fill_ff;
      sum_in       = sum_ff;
      sq_in        = sq_ff;
      price_in     = price_ff;
      spread_in    = spread_ff;
      root_in      = root_ff;
      mean_in      = mean_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      lower_in     = lower_ff;
      middle_in    = middle_ff;
      upper_in     = upper_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               price_in = req_price;
               state_in = ST_SQP;
            end
         end
         ST_SQP: state_in = ST_SQO;
         ST_SQO: state_in = ST_ADD;
         ST_ADD: begin
            // Product here is the new price squared; sums may wrap until
            // the evicted price comes out next state
            sum_in   = sum_ff + SW'(price_ff);
            sq_in    = sq_ff + QW'(prod);
            state_in = ST_SUB;
         end
         ST_SUB: begin
            // Product here is the evicted price squared
            if (win_full) begin
               sum_in = sum_ff - SW'(old_price);
               sq_in  = sq_ff - QW'(prod);
            end else begin
               fill_in = fill_ff + 1'b1;
            end
            if (32'(slot_ff) == 32'(n_len) - 1) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + 1'b1;
            end
            if (win_full || (WLEN_W'(fill_ff + 1'b1) == n_len)) begin
               state_in = ST_MQL;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_MQL: state_in = ST_MQH;
         ST_MQH: begin
            spread_in = VW'(prod);
            state_in  = ST_MSS;
         end
         ST_MSS: begin
            spread_in = spread_ff + (VW'(prod) << MUL_W);
            state_in  = ST_VAR;
         end
         ST_VAR: state_in = ST_ROOT;
         ST_ROOT: begin
            if (iter_stat.done) begin
               root_in  = iter_res;
               state_in = ST_MEAN;
            end
         end
         ST_MEAN: begin
            if (iter_stat.done) begin
               mean_in  = iter_res[SW-1:0];
               state_in = ST_DEV;
            end
         end
         ST_DEV: begin
            if (iter_stat.done) begin
               state_in = ST_OFS;
            end
         end
         ST_OFS: begin
            // Hold here until the output register frees up
            if (rsp_free) begin
               lower_in     = lo_big[LOWER_W-1:0];
               middle_in    = MIDDLE_W'(mean_ff);
               upper_in     = up_big[UPPER_W-1:0];
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase

      // Register writes must come only while idle, which the block does not
      // enforce; a window length write restarts the window
      if (csr_wr) begin
         case (csr_idx)
            REG_WLEN: begin
               wlen_in = csr_pwdata[WLEN_W-1:0];
               slot_in = '0;
               fill_in = '0;
               sum_in  = '0;
               sq_in   = '0;
            end
            REG_MULT: mult_in = csr_pwdata[MULT_W-1:0];
            default:  mult_in = mult_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         wlen_ff      <= WLEN_W'(WLEN_RESET);
         mult_ff      <= MULT_W'(MULT_RESET);
         slot_ff      <= '0;
         fill_ff      <= '0;
         sum_ff       <= '0;
         sq_ff        <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wlen_ff      <= wlen_in;
         mult_ff      <= mult_in;
         slot_ff      <= slot_in;
         fill_ff      <= fill_in;
         sum_ff       <= sum_in;
         sq_ff        <= sq_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      price_ff  <= price_in;
      spread_ff <= spread_in;
      root_ff   <= root_in;
      mean_ff   <= mean_in;
      lower_ff  <= lower_in;
      middle_ff <= middle_in;
      upper_ff  <= upper_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_lower_band  = lower_ff;
   assign rsp_middle_band = middle_ff;
   assign rsp_upper_band  = upper_ff;

   a_rsp_from_bands: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OFS))
      else $error("engine: response raised outside band formation");

   a_fill_bounded: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= n_len)
      else $error("engine: fill count beyond window length");

   a_slot_bounded: assert property (@(posedge clock) disable iff (reset)
      32'(slot_ff) < 32'(n_len))
      else $error("engine: write slot beyond window length");

endmodule
